// ----- hdl/two_stack_gap_buffer_macros.svh -----
// Assertion macros shared by the gap buffer RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TWO_STACK_GAP_BUFFER_MACROS_SVH
`define TWO_STACK_GAP_BUFFER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TSGB_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define TSGB_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSGB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/tsgb_pkg.sv -----
// Shared constants, request and status codes, and the memory request struct
// for the two-stack gap buffer. No dependencies.
package tsgb_pkg;

    // Capacity of the text line, in characters, and derived widths.
    localparam int BUFFER_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int TOT_W        = LEN_W + 1;

    // Fixed field widths of the request and response items.
    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 10;

    // Width wide enough to compare counts, positions and lengths.
    localparam int CMP_A_W = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;
    localparam int CMP_W   = (CMP_A_W > POS_W) ? CMP_A_W : POS_W;

    // Request codes.
    typedef enum logic [2:0] {
        OP_INSERT       = 3'd0,
        OP_MOVE_LEFT    = 3'd1,
        OP_MOVE_RIGHT   = 3'd2,
        OP_DELETE_LEFT  = 3'd3,
        OP_DELETE_RIGHT = 3'd4,
        OP_READ         = 3'd5,
        OP_CLEAR        = 3'd6,
        OP_MARK_SAVED   = 3'd7
    } tsgb_op_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } tsgb_status_t;

    // One read port and one write port request toward a stack memory.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_data;
    } tsgb_mem_req_t;

endpackage

// ----- hdl/tsgb_req_if.sv -----
// Request channel of the gap buffer: valid/ready handshake plus request fields.
// Depends on tsgb_pkg.
interface tsgb_req_if;
    import tsgb_pkg::*;

    logic                valid;
    logic                ready;
    tsgb_op_t            req_type;
    logic [CHAR_W-1:0]   char_in;
    logic [COUNT_W-1:0]  count;
    logic [POS_W-1:0]    position;

    modport source (output valid, output req_type, output char_in, output count,
                    output position, input ready);
    modport sink   (input valid, input req_type, input char_in, input count,
                    input position, output ready);
endinterface

// ----- hdl/tsgb_rsp_if.sv -----
// Response channel of the gap buffer: valid/ready handshake plus result fields.
// Depends on tsgb_pkg.
interface tsgb_rsp_if;
    import tsgb_pkg::*;

    logic                valid;
    logic                ready;
    tsgb_status_t        status;
    logic [CHAR_W-1:0]   char_out;
    logic [LEN_W-1:0]    left_count;
    logic [LEN_W-1:0]    right_count;
    logic                modified;

    modport source (output valid, output status, output char_out, output left_count,
                    output right_count, output modified, input ready);
    modport sink   (input valid, input status, input char_out, input left_count,
                    input right_count, input modified, output ready);
endinterface

// ----- hdl/tsgb_stack.sv -----
// One stack store of the gap buffer: a synchronous memory with one write port
// and one read port, read data registered. Depends on tsgb_pkg.
module tsgb_stack (
    input  logic                          clk,
    input  tsgb_pkg::tsgb_mem_req_t       mem_req,
    output logic [tsgb_pkg::CHAR_W-1:0]   rd_data
);
    import tsgb_pkg::*;

    logic [CHAR_W-1:0] mem [BUFFER_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;

    // Write and registered read; entries hold no reset value.
    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data_reg <= mem[mem_req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- hdl/two_stack_gap_buffer.sv -----
// Two-stack gap buffer top level: request sequencer, both stack memories and
// the response register. Depends on tsgb_pkg, tsgb_req_if, tsgb_rsp_if,
// tsgb_stack and two_stack_gap_buffer_macros.svh.
//
// The block holds one line of text of up to BUFFER_DEPTH characters as two
// stacks around a cursor and takes one request at a time. Insert, delete,
// clear, mark-saved and a read past the end of the text go from acceptance
// straight to the finish state. A read inside the text passes through the
// read state first, to capture the registered read data of the stack memory.
// A cursor move of n characters streams one character per cycle from the top
// of one stack memory to the top of the other, reads and writes overlapped.
// The result of a request sits in an output register; the next request is
// taken while it waits, and a request only stalls at its end if the previous
// result is still not taken. No clearing pass is needed after reset.
`include "two_stack_gap_buffer_macros.svh"

module two_stack_gap_buffer (
    input  logic       clk,
    input  logic       rst_n,
    tsgb_req_if.sink   req,
    tsgb_rsp_if.source rsp
);
    import tsgb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_READ,
        S_FINISH
    } tsgb_state_t;

    tsgb_state_t       state_reg;
    logic [LEN_W-1:0]  left_len_reg;
    logic [LEN_W-1:0]  right_len_reg;
    logic              dirty_reg;
    tsgb_status_t      status_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic              dir_left_reg;
    logic              pend_reg;
    logic              rd_left_reg;

    logic              rsp_valid_reg;
    tsgb_status_t      rsp_status_reg;
    logic [CHAR_W-1:0] rsp_char_reg;
    logic [LEN_W-1:0]  rsp_left_reg;
    logic [LEN_W-1:0]  rsp_right_reg;
    logic              rsp_modified_reg;

    tsgb_mem_req_t     lreq;
    tsgb_mem_req_t     rreq;
    logic [CHAR_W-1:0] l_rdata;
    logic [CHAR_W-1:0] r_rdata;

    logic              acc;
    logic [TOT_W-1:0]  total_w;
    logic              full;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  left_x;
    logic [CMP_W-1:0]  right_x;
    logic [CMP_W-1:0]  off_x;
    logic [CMP_W-1:0]  ridx_x;
    logic [LEN_W-1:0]  clip_left;
    logic [LEN_W-1:0]  clip_right;
    logic              in_left;
    logic              in_right;
    logic              issue;
    logic              out_free;

    // Stack memories.
    tsgb_stack u_left (
        .clk     (clk),
        .mem_req (lreq),
        .rd_data (l_rdata)
    );

    tsgb_stack u_right (
        .clk     (clk),
        .mem_req (rreq),
        .rd_data (r_rdata)
    );

    // Handshake.
    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.char_out    = rsp_char_reg;
    assign rsp.left_count  = rsp_left_reg;
    assign rsp.right_count = rsp_right_reg;
    assign rsp.modified    = rsp_modified_reg;

    // Request decode: fullness, clipped counts and read position split.
    assign total_w    = {1'b0, left_len_reg} + {1'b0, right_len_reg};
    assign full       = (total_w >= TOT_W'(BUFFER_DEPTH));
    assign cnt_x      = CMP_W'(req.count);
    assign pos_x      = CMP_W'(req.position);
    assign left_x     = CMP_W'(left_len_reg);
    assign right_x    = CMP_W'(right_len_reg);
    assign clip_left  = (cnt_x < left_x) ? LEN_W'(cnt_x) : left_len_reg;
    assign clip_right = (cnt_x < right_x) ? LEN_W'(cnt_x) : right_len_reg;
    assign off_x      = pos_x - left_x;
    assign ridx_x     = right_x - off_x - CMP_W'(1);
    assign in_left    = (pos_x < left_x);
    assign in_right   = !in_left && (off_x < right_x);

    // A move issues one source read per cycle while characters remain.
    assign issue = (rem_reg != '0);

    // Memory requests.
    always_comb
    begin
        lreq = '0;
        rreq = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    case (req.req_type)
                        OP_INSERT:
                        begin
                            lreq.wr_en   = !full;
                            lreq.wr_addr = ADDR_W'(left_len_reg);
                            lreq.wr_data = req.char_in;
                        end
                        OP_READ:
                        begin
                            lreq.rd_en   = in_left;
                            lreq.rd_addr = ADDR_W'(pos_x);
                            rreq.rd_en   = in_right;
                            rreq.rd_addr = ADDR_W'(ridx_x);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                if (dir_left_reg)
                begin
                    lreq.rd_en   = issue;
                    lreq.rd_addr = ADDR_W'(left_len_reg - LEN_W'(1));
                    rreq.wr_en   = pend_reg;
                    rreq.wr_addr = ADDR_W'(right_len_reg);
                    rreq.wr_data = l_rdata;
                end
                else
                begin
                    rreq.rd_en   = issue;
                    rreq.rd_addr = ADDR_W'(right_len_reg - LEN_W'(1));
                    lreq.wr_en   = pend_reg;
                    lreq.wr_addr = ADDR_W'(left_len_reg);
                    lreq.wr_data = r_rdata;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer, lengths, flags and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            left_len_reg     <= '0;
            right_len_reg    <= '0;
            dirty_reg        <= 1'b0;
            status_reg       <= ST_OK;
            char_reg         <= '0;
            rem_reg          <= '0;
            dir_left_reg     <= 1'b0;
            pend_reg         <= 1'b0;
            rd_left_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            rsp_status_reg   <= ST_OK;
            rsp_char_reg     <= '0;
            rsp_left_reg     <= '0;
            rsp_right_reg    <= '0;
            rsp_modified_reg <= 1'b0;
        end
        else
        begin
            // A taken result empties the output register unless the finish
            // state refills it in the same cycle.
            if (rsp.ready && state_reg != S_FINISH)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        status_reg <= ST_OK;
                        char_reg   <= '0;
                        state_reg  <= S_FINISH;
                        case (req.req_type)
                            OP_INSERT:
                            begin
                                if (full)
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    left_len_reg <= left_len_reg + LEN_W'(1);
                                    dirty_reg    <= 1'b1;
                                end
                            end
                            OP_MOVE_LEFT:
                            begin
                                rem_reg      <= clip_left;
                                dir_left_reg <= 1'b1;
                                pend_reg     <= 1'b0;
                                state_reg    <= S_MOVE;
                            end
                            OP_MOVE_RIGHT:
                            begin
                                rem_reg      <= clip_right;
                                dir_left_reg <= 1'b0;
                                pend_reg     <= 1'b0;
                                state_reg    <= S_MOVE;
                            end
                            OP_DELETE_LEFT:
                            begin
                                left_len_reg <= left_len_reg - clip_left;
                                dirty_reg    <= 1'b1;
                            end
                            OP_DELETE_RIGHT:
                            begin
                                right_len_reg <= right_len_reg - clip_right;
                                dirty_reg     <= 1'b1;
                            end
                            OP_READ:
                            begin
                                if (in_left || in_right)
                                begin
                                    rd_left_reg <= in_left;
                                    state_reg   <= S_READ;
                                end
                                else
                                begin
                                    status_reg <= ST_RANGE;
                                end
                            end
                            OP_CLEAR:
                            begin
                                left_len_reg  <= '0;
                                right_len_reg <= '0;
                                dirty_reg     <= 1'b0;
                            end
                            OP_MARK_SAVED:
                            begin
                                dirty_reg <= 1'b0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                // Stream characters between the stack tops; the write of a
                // character lands in the cycle after its read.
                S_MOVE:
                begin
                    pend_reg <= issue;
                    if (issue)
                    begin
                        rem_reg <= rem_reg - LEN_W'(1);
                    end
                    if (dir_left_reg)
                    begin
                        left_len_reg  <= left_len_reg - LEN_W'(issue);
                        right_len_reg <= right_len_reg + LEN_W'(pend_reg);
                    end
                    else
                    begin
                        right_len_reg <= right_len_reg - LEN_W'(issue);
                        left_len_reg  <= left_len_reg + LEN_W'(pend_reg);
                    end
                    if (!issue)
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                // Capture the character read from the selected stack.
                S_READ:
                begin
                    char_reg  <= rd_left_reg ? l_rdata : r_rdata;
                    state_reg <= S_FINISH;
                end

                // Hand the result to the output register once it is free.
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg    <= 1'b1;
                        rsp_status_reg   <= status_reg;
                        rsp_char_reg     <= char_reg;
                        rsp_left_reg     <= left_len_reg;
                        rsp_right_reg    <= right_len_reg;
                        rsp_modified_reg <= dirty_reg;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The text never grows beyond the capacity.
    `TSGB_ASSERT_ALWAYS(a_total_bounded, total_w <= TOT_W'(BUFFER_DEPTH), "gap buffer overfilled")
    // Neither stack memory is read and written in the same cycle.
    `TSGB_ASSERT_ALWAYS(a_no_rw_overlap, !(lreq.rd_en && lreq.wr_en) && !(rreq.rd_en && rreq.wr_en), "stack read and write overlap")
    // A move never has more characters left than its source stack holds.
    `TSGB_ASSERT_SAME(a_move_bounded, state_reg == S_MOVE && dir_left_reg, rem_reg <= left_len_reg, "move count exceeds left stack")
    `TSGB_ASSERT_SAME(a_move_bounded_r, state_reg == S_MOVE && !dir_left_reg, rem_reg <= right_len_reg, "move count exceeds right stack")
    // An accepted insert into a buffer with room grows the left stack by one.
    `TSGB_ASSERT_NEXT(a_insert_grows, acc && req.req_type == OP_INSERT && !full, left_len_reg == $past(left_len_reg) + LEN_W'(1), "insert did not grow left stack")
endmodule
